// ===== rtl/core/phist_pkg.sv =====
// ----------------------------------------------------------------------------
// phist_pkg
// Shared types and constants for the pixel histogram.
// ----------------------------------------------------------------------------
package phist_pkg;

  localparam int BIN_W = 17;
  localparam int CFG_W = 9;
  localparam int CMD_W = 2;
  localparam int VAL_W = 8;

  localparam logic [BIN_W-1:0] BIN_MAX = 17'h1FFFF;
  localparam logic [CFG_W-1:0] BIN_COUNT_RESET = 9'd256;

  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [BIN_W-1:0] bin_t;

  localparam cmd_t CMD_COUNT = 2'd0;
  localparam cmd_t CMD_READ  = 2'd1;
  localparam cmd_t CMD_CLEAR = 2'd2;

endpackage

// ===== rtl/core/phist_ram.sv =====
// ----------------------------------------------------------------------------
// phist_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module phist_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/pixel_histogram.sv =====
// ----------------------------------------------------------------------------
// pixel_histogram
// Saturating histogram of 8-bit pixel values, bins held in one RAM.
//
//   channel  direction  signals                         notes
//   in       sink       in_valid in_ready cmd value     count / read / clear
//   out      source     out_valid out_ready bin_total   one beat per read
//                       out_of_range
//   cfg      sink       cfg_we cfg_wdata                bin_count, no wait
//
// One item per cycle unless stalled: a beat reads its bin when accepted and
// updates it in the next cycle; a back-to-back hit on the same bin is forwarded.
// A read beat moves from stage 1 to the output register, waiting while stalled.
// Clear empties a per-bin valid flop array, not the RAM.
// Reset clears the valid flops at once, so no clearing pass is needed.
// in_ready drops only while a read waits behind an output beat not taken.
// ----------------------------------------------------------------------------
module pixel_histogram #(
  parameter int IMAGE_SIDE = 256,
  parameter int MAX_BINS   = 256
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  phist_pkg::cmd_t          cmd,
  input  logic [7:0]               value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [16:0]              bin_total,
  output logic                     out_of_range,
  input  logic                     cfg_we,
  input  logic [8:0]               cfg_wdata
);
  import phist_pkg::*;

  localparam int AW        = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int SIDE_SQ   = IMAGE_SIDE * IMAGE_SIDE;
  localparam bin_t CAP     = (SIDE_SQ > int'(BIN_MAX)) ? BIN_MAX : BIN_W'(SIDE_SQ);
  localparam logic [CFG_W-1:0] LIMIT_MAX = CFG_W'(MAX_BINS);

  logic [CFG_W-1:0] bin_count;
  logic [CFG_W-1:0] limit;
  logic             accept;
  logic             in_range;

  // stage 1 (RAM data available)
  logic             s1_valid;
  cmd_t             s1_cmd;
  logic [AW-1:0]    s1_addr;
  logic             s1_in_range;
  logic             s1_fire;
  logic             stall;

  // last write, for back-to-back forwarding
  logic             wb_valid;
  logic [AW-1:0]    wb_addr;
  bin_t             wb_data;

  logic [MAX_BINS-1:0] bin_valid;
  bin_t             rdata;
  bin_t             old_total;
  bin_t             new_total;
  logic             ram_we;

  always_ff @(posedge clk) begin
    if (rst) begin
      bin_count <= BIN_COUNT_RESET;
    end else if (cfg_we) begin
      bin_count <= cfg_wdata;
    end
  end

  assign limit    = (bin_count > LIMIT_MAX) ? LIMIT_MAX : bin_count;
  assign in_range = {1'b0, value} < limit;

  assign stall    = s1_valid && (s1_cmd == CMD_READ) && out_valid && !out_ready;
  assign in_ready = !stall;
  assign accept   = in_valid && in_ready;
  assign s1_fire  = s1_valid && !stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd      <= cmd;
      s1_addr     <= value[AW-1:0];
      s1_in_range <= in_range;
    end
  end

  phist_ram #(
    .WIDTH (BIN_W),
    .DEPTH (MAX_BINS),
    .AW    (AW)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (new_total),
    .re    (accept),
    .raddr (value[AW-1:0]),
    .rdata (rdata)
  );

  // RAM may hold stale data for a bin cleared or written in the prior beat
  always_comb begin
    if (wb_valid && (wb_addr == s1_addr)) begin
      old_total = wb_data;
    end else if (bin_valid[s1_addr]) begin
      old_total = rdata;
    end else begin
      old_total = '0;
    end
  end

  assign new_total = (old_total < CAP) ? old_total + BIN_W'(1) : old_total;
  assign ram_we    = s1_fire && (s1_cmd == CMD_COUNT) && s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid  <= 1'b0;
      bin_valid <= '0;
    end else if (s1_fire) begin
      wb_valid <= ram_we;
      if (s1_cmd == CMD_CLEAR) begin
        bin_valid <= '0;
      end else if (ram_we) begin
        bin_valid[s1_addr] <= 1'b1;
      end
    end else if (!stall) begin
      wb_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      wb_addr <= s1_addr;
      wb_data <= new_total;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && (s1_cmd == CMD_READ)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1_cmd == CMD_READ)) begin
      bin_total    <= s1_in_range ? old_total : '0;
      out_of_range <= !s1_in_range;
    end
  end

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (out_valid && !out_ready && s1_valid && s1_cmd == CMD_READ))
    else $error("input stalled without a blocked read beat");

  a_write_only_count: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (s1_valid && s1_cmd == CMD_COUNT && s1_in_range))
    else $error("bin write from a beat that is not an in-range count");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_cmd == CMD_CLEAR) |=> (bin_valid == '0))
    else $error("clear left a bin marked valid");

  a_result_from_read: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !$past(out_valid)) |-> $past(s1_fire && s1_cmd == CMD_READ))
    else $error("result beat without a read");

  a_total_capped: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (new_total <= CAP))
    else $error("bin total above its cap");

endmodule
